// ===== rtl/core/goi_pkg.sv =====
// Package for the grid obstacle inflation block: sizes, cell codes, state
// encoding and the word types passed between the top level and the scanner.
// No dependencies.
package goi_pkg;

  // Store dimensions and the largest growth radius.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 15;

  // Address bits per axis; the store is addressed as {row, column}.
  localparam int X_W       = $clog2(MAX_WIDTH);
  localparam int Y_W       = $clog2(MAX_HEIGHT);
  localparam int ADDR_W    = X_W + Y_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  // Working width of coordinates: holds a map size, a column plus the radius.
  localparam int XY_W = (X_W > Y_W) ? X_W : Y_W;
  localparam int CO_W = ((XY_W > 9) ? XY_W : 9) + 1;

  // Fixed field widths.
  localparam int CELL_W = 8;
  localparam int SIZE_W = 9;
  localparam int RAD_W  = 4;
  localparam int IDX_W  = 2;

  typedef logic signed [CELL_W-1:0] cell_t;
  typedef logic [CO_W-1:0]          coord_t;

  // Cell codes.
  localparam cell_t CELL_OCCUPIED = 8'sd100;
  localparam cell_t CELL_FREE     = 8'sd0;
  localparam cell_t CELL_UNKNOWN  = -8'sd1;
  localparam cell_t CELL_EMPTY    = -8'sd128;

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_MAP_WIDTH      = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAP_HEIGHT     = 2'd1;
  localparam logic [IDX_W-1:0] REG_INFLATE_RADIUS = 2'd2;

  // Scanner states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } goi_state_t;

  // Query command from the top level to the scanner.
  typedef struct packed {
    logic              start;
    logic [7:0]        cx;
    logic [7:0]        cy;
    logic [RAD_W-1:0]  radius;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } goi_cmd_t;

  // Finished query result from the scanner.
  typedef struct packed {
    logic  valid;
    cell_t value;
    logic  oor;
  } goi_res_t;

  // Store address of a cell.
  function automatic logic [ADDR_W-1:0] goi_addr(input coord_t x, input coord_t y);
    goi_addr = {y[Y_W-1:0], x[X_W-1:0]};
  endfunction

endpackage

// ===== rtl/core/goi_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
module goi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/goi_scan.sv =====
// Query scanner: clips the square window to the map, walks it one cell per
// cycle through the map memory read port and forms the inflated value.
// Depends on goi_pkg.
module goi_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  goi_pkg::goi_cmd_t     cmd,
  output logic                  idle,
  output logic                  rd_en,
  output logic [goi_pkg::ADDR_W-1:0] rd_addr,
  input  logic [goi_pkg::CELL_W-1:0] rd_data,
  output goi_pkg::goi_res_t     res,
  input  logic                  res_take
);
  import goi_pkg::*;

  goi_state_t state_r, state_nxt;

  coord_t cx_r, cx_nxt;
  coord_t cy_r, cy_nxt;
  coord_t r_r, r_nxt;
  coord_t w_r, w_nxt;
  coord_t h_r, h_nxt;
  coord_t x0_r, x0_nxt;
  coord_t x1_r, x1_nxt;
  coord_t y1_r, y1_nxt;
  coord_t x_r, x_nxt;
  coord_t y_r, y_nxt;
  logic   hit_r, hit_nxt;
  cell_t  own_r, own_nxt;
  logic   oor_r, oor_nxt;
  logic   rv_r, rv_nxt;
  logic   rown_r, rown_nxt;

  coord_t x_lo, x_hi_raw, x_hi, y_lo, y_hi_raw, y_hi;
  logic   oor_now, x_last, y_last;
  cell_t  rd_cell;

  assign rd_cell = cell_t'(rd_data);

  // Window bounds, clipped to the map; used in the setup cycle.
  always_comb begin
    x_lo     = (cx_r >= r_r) ? (cx_r - r_r) : '0;
    y_lo     = (cy_r >= r_r) ? (cy_r - r_r) : '0;
    x_hi_raw = cx_r + r_r;
    y_hi_raw = cy_r + r_r;
    x_hi     = (x_hi_raw > (w_r - coord_t'(1))) ? (w_r - coord_t'(1)) : x_hi_raw;
    y_hi     = (y_hi_raw > (h_r - coord_t'(1))) ? (h_r - coord_t'(1)) : y_hi_raw;
    oor_now  = (cx_r >= w_r) || (cy_r >= h_r);
    x_last   = (x_r == x1_r);
    y_last   = (y_r == y1_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = oor_now ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (x_last && y_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs: read requests, busy flag and the finished result.
  always_comb begin
    idle      = 1'b0;
    rd_en     = 1'b0;
    res.valid = 1'b0;
    case (state_r)
      ST_IDLE:  idle = 1'b1;
      ST_SCAN:  rd_en = 1'b1;
      ST_DONE:  res.valid = 1'b1;
      default:  idle = 1'b0;
    endcase
    rd_addr = goi_addr(x_r, y_r);
    res.oor = oor_r;
    if (oor_r) begin
      res.value = CELL_EMPTY;
    end else if (hit_r) begin
      res.value = CELL_OCCUPIED;
    end else if ((own_r == CELL_FREE) || (own_r == CELL_UNKNOWN)) begin
      res.value = own_r;
    end else begin
      res.value = CELL_EMPTY;
    end
  end

  // Datapath: capture the command, set up bounds, step the window and
  // fold each returned word into the hit flag and the own cell value.
  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    r_nxt    = r_r;
    w_nxt    = w_r;
    h_nxt    = h_r;
    x0_nxt   = x0_r;
    x1_nxt   = x1_r;
    y1_nxt   = y1_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    hit_nxt  = hit_r;
    own_nxt  = own_r;
    oor_nxt  = oor_r;
    rv_nxt   = rd_en;
    rown_nxt = rd_en && (x_r == cx_r) && (y_r == cy_r);

    if (state_r == ST_IDLE && cmd.start) begin
      cx_nxt = coord_t'(cmd.cx);
      cy_nxt = coord_t'(cmd.cy);
      r_nxt  = (coord_t'(cmd.radius) > coord_t'(MAX_RADIUS)) ?
               coord_t'(MAX_RADIUS) : coord_t'(cmd.radius);
      w_nxt  = (coord_t'(cmd.width) > coord_t'(MAX_WIDTH)) ?
               coord_t'(MAX_WIDTH) : coord_t'(cmd.width);
      h_nxt  = (coord_t'(cmd.height) > coord_t'(MAX_HEIGHT)) ?
               coord_t'(MAX_HEIGHT) : coord_t'(cmd.height);
    end

    if (state_r == ST_SETUP) begin
      x0_nxt  = x_lo;
      x1_nxt  = x_hi;
      y1_nxt  = y_hi;
      x_nxt   = x_lo;
      y_nxt   = y_lo;
      hit_nxt = 1'b0;
      oor_nxt = oor_now;
    end

    if (state_r == ST_SCAN) begin
      if (x_last) begin
        x_nxt = x0_r;
        y_nxt = y_r + coord_t'(1);
      end else begin
        x_nxt = x_r + coord_t'(1);
      end
    end

    if (rv_r) begin
      if (rd_cell == CELL_OCCUPIED) begin
        hit_nxt = 1'b1;
      end
      if (rown_r) begin
        own_nxt = rd_cell;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    r_r    <= r_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    x0_r   <= x0_nxt;
    x1_r   <= x1_nxt;
    y1_r   <= y1_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    hit_r  <= hit_nxt;
    own_r  <= own_nxt;
    oor_r  <= oor_nxt;
    rown_r <= rown_nxt;
  end

endmodule

// ===== rtl/core/grid_obstacle_inflation.sv =====
// Grid obstacle inflation: each write word stores one map cell and gives no
// result. A query scans its window, clipped to the map, of up to 31 x 31 =
// 961 cells, with one map memory read per cycle; a query outside the map
// skips the scan. One query is in flight at a time; the next word is taken
// once the result is handed over.
// Synchronous active-low reset restores the size and radius registers; map
// contents are not cleared.
module grid_obstacle_inflation (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input word channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [7:0]                   in_cell_x,
  input  logic [7:0]                   in_cell_y,
  input  logic signed [7:0]            in_cell_value,
  // Result word channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [7:0]            out_inflated_value,
  output logic                         out_out_of_range,
  // Configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [goi_pkg::IDX_W-1:0]    cfg_index,
  input  logic [goi_pkg::SIZE_W-1:0]   cfg_data
);
  import goi_pkg::*;

  logic [SIZE_W-1:0] map_width_r, map_width_nxt;
  logic [SIZE_W-1:0] map_height_r, map_height_nxt;
  logic [RAD_W-1:0]  radius_r, radius_nxt;

  logic              out_valid_r, out_valid_nxt;
  cell_t             out_value_r, out_value_nxt;
  logic              out_oor_r, out_oor_nxt;

  logic              in_accept;
  logic              in_store;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;
  logic              scan_idle;
  logic              res_take;
  goi_cmd_t          cmd;
  goi_res_t          res;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    radius_nxt     = radius_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_WIDTH:      map_width_nxt  = cfg_data;
        REG_MAP_HEIGHT:     map_height_nxt = cfg_data;
        REG_INFLATE_RADIUS: radius_nxt     = cfg_data[RAD_W-1:0];
        default:            map_width_nxt  = map_width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= SIZE_W'(256);
      map_height_r <= SIZE_W'(256);
      radius_r     <= RAD_W'(3);
    end else begin
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
      radius_r     <= radius_nxt;
    end
  end

  // Input words are taken only while the scanner is idle.
  assign in_stall  = !scan_idle;
  assign in_accept = in_valid && !in_stall;
  assign in_store  = (32'(in_cell_x) < 32'(MAX_WIDTH)) &&
                     (32'(in_cell_y) < 32'(MAX_HEIGHT));
  assign ram_we    = in_accept && (in_kind == KIND_WRITE) && in_store;
  assign ram_waddr = goi_addr(coord_t'(in_cell_x), coord_t'(in_cell_y));

  always_comb begin
    cmd.start  = in_accept && (in_kind == KIND_QUERY);
    cmd.cx     = in_cell_x;
    cmd.cy     = in_cell_y;
    cmd.radius = radius_r;
    cmd.width  = map_width_r;
    cmd.height = map_height_r;
  end

  // Map memory.
  goi_ram #(
    .WIDTH (CELL_W),
    .DEPTH (RAM_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_cell_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Window scanner.
  goi_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .idle     (scan_idle),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res      (res),
    .res_take (res_take)
  );

  // Output register: loads a finished result when empty or being drained.
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_oor_nxt   = out_oor_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res.value;
      out_oor_nxt   = res.oor;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_inflated_value = out_value_r;
  assign out_out_of_range   = out_oor_r;

`ifndef ASSERT_OFF
  // A word outside the map always reads as empty.
  a_oor_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_inflated_value == CELL_EMPTY)
    else $error("out-of-range result is not empty");

  // Inflated values are one of the four cell codes.
  a_value_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_inflated_value == CELL_OCCUPIED) ||
                  (out_inflated_value == CELL_FREE) ||
                  (out_inflated_value == CELL_UNKNOWN) ||
                  (out_inflated_value == CELL_EMPTY))
    else $error("result value is not a cell code");

  // The map is never written while a scan reads it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> scan_idle && !rd_en)
    else $error("map write during a scan");

  // An accepted query holds off the next word.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_kind == KIND_QUERY) |=> in_stall)
    else $error("input taken while a query is in flight");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for grid_obstacle_inflation: a directed table, then random phases
// of map writes and inflated-cell queries checked against a predictor kept here.
// Depends on goi_pkg and the grid_obstacle_inflation top level.
module tb;
  import goi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 1000;
  localparam int PHASE_WORDS = 50;
  // Index with no register behind it.
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    cell_t value;
    logic  oor;
  } cell_result_t;

  typedef enum logic {ROW_REG, ROW_WORD} row_act_t;

  typedef struct packed {
    row_act_t          act;
    logic              kind;
    logic [7:0]        x;
    logic [7:0]        y;
    cell_t             value;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] data;
    logic              typed;
    cell_result_t      want;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_kind = KIND_WRITE;
  logic [7:0]              in_cell_x = '0;
  logic [7:0]              in_cell_y = '0;
  logic signed [7:0]       in_cell_value = '0;
  logic                    out_stall = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [SIZE_W-1:0]       cfg_data = '0;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [7:0]       out_inflated_value;
  logic                    out_out_of_range;
  logic                    cfg_ready;

  // Local copy of the map and the registers, updated as words are accepted.
  cell_t             grid_copy [0:RAM_DEPTH-1];
  bit                cell_written [0:RAM_DEPTH-1];
  logic [SIZE_W-1:0] width_reg = 9'd256;
  logic [SIZE_W-1:0] height_reg = 9'd256;
  logic [RAD_W-1:0]  radius_reg = 4'd3;

  cell_result_t awaited_cells [$];
  stim_row_t    directed_rows [$];
  int           error_count = 0;
  int unsigned  cycle_count = 0;
  int           tx_quiet = 0;
  int           rx_quiet = 0;

  grid_obstacle_inflation dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_cell_x          (in_cell_x),
    .in_cell_y          (in_cell_y),
    .in_cell_value      (in_cell_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_inflated_value (out_inflated_value),
    .out_out_of_range   (out_out_of_range),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  function automatic int slot(input int x, input int y);
    return y * MAX_WIDTH + x;
  endfunction

  // Size in use after saturation at the store size.
  function automatic int used_span(input logic [SIZE_W-1:0] size, input int cap);
    return (int'(size) > cap) ? cap : int'(size);
  endfunction

  // Square neighborhood of a cell, clipped to the map in use.
  function automatic void clip_window(input int x, input int y,
                                      output int x0, output int x1,
                                      output int y0, output int y1);
    int rad;
    int ew;
    int eh;
    rad = (int'(radius_reg) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    ew = used_span(width_reg, MAX_WIDTH);
    eh = used_span(height_reg, MAX_HEIGHT);
    x0 = (x >= rad) ? x - rad : 0;
    y0 = (y >= rad) ? y - rad : 0;
    x1 = (x + rad > ew - 1) ? ew - 1 : x + rad;
    y1 = (y + rad > eh - 1) ? eh - 1 : y + rad;
  endfunction

  // Inflated value of one cell under the current map and registers.
  function automatic cell_result_t inflate_cell(input int x, input int y);
    cell_result_t res;
    cell_t        own;
    int           x0, x1, y0, y1, xx, yy;
    res.oor = 1'b0;
    res.value = CELL_EMPTY;
    if (x >= used_span(width_reg, MAX_WIDTH) || y >= used_span(height_reg, MAX_HEIGHT)) begin
      res.oor = 1'b1;
      return res;
    end
    clip_window(x, y, x0, x1, y0, y1);
    for (yy = y0; yy <= y1; yy++) begin
      for (xx = x0; xx <= x1; xx++) begin
        if (grid_copy[slot(xx, yy)] == CELL_OCCUPIED) begin
          res.value = CELL_OCCUPIED;
          return res;
        end
      end
    end
    own = grid_copy[slot(x, y)];
    if (own == CELL_FREE || own == CELL_UNKNOWN) res.value = own;
    return res;
  endfunction

  // Pause before a word: mostly random, with runs of back-to-back words.
  function automatic int draw_pause(inout int quiet);
    if (quiet > 0) begin
      quiet = quiet - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Raw cell value; occ_pct sets how often a cell is occupied.
  function automatic cell_t pick_value(input int occ_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < occ_pct) return CELL_OCCUPIED;
    if (roll < occ_pct + 25) return CELL_FREE;
    if (roll < occ_pct + 50) return CELL_UNKNOWN;
    return cell_t'($urandom_range(0, 255));
  endfunction

  function automatic stim_row_t reg_row(input logic [IDX_W-1:0] idx,
                                        input logic [SIZE_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.act = ROW_REG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic stim_row_t write_row(input int x, input int y, input cell_t value);
    stim_row_t row;
    row = '0;
    row.act = ROW_WORD;
    row.kind = KIND_WRITE;
    row.x = 8'(x);
    row.y = 8'(y);
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t query_row(input int x, input int y, input logic typed,
                                          input cell_t want_value, input logic want_oor);
    stim_row_t row;
    row = '0;
    row.act = ROW_WORD;
    row.kind = KIND_QUERY;
    row.x = 8'(x);
    row.y = 8'(y);
    row.typed = typed;
    row.want.value = want_value;
    row.want.oor = want_oor;
    return row;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Hand one input word to the block and record what it should cause.
  task automatic send_word(input logic kind, input int x, input int y, input cell_t value,
                           input logic typed, input cell_result_t want);
    int gap;
    gap = draw_pause(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_cell_x <= 8'(x);
    in_cell_y <= 8'(y);
    in_cell_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == KIND_WRITE) begin
      grid_copy[slot(x, y)] = value;
      cell_written[slot(x, y)] = 1'b1;
    end else begin
      awaited_cells.insert(awaited_cells.size(), typed ? want : inflate_cell(x, y));
    end
  endtask

  // Register writes happen only once the block has gone idle.
  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    in_valid <= 1'b0;
    while (awaited_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAP_WIDTH: width_reg = data;
      REG_MAP_HEIGHT: height_reg = data;
      REG_INFLATE_RADIUS: radius_reg = data[RAD_W-1:0];
      default: ;
    endcase
  endtask

  // One random phase under a fixed map size and radius. Queries sit mostly in
  // a small focus area; every cell a query can read is written beforehand.
  task automatic run_phase(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [RAD_W-1:0] r, input int words);
    cell_result_t none;
    int ew, eh, fw, fh, fx, fy, rad, done, x, y, x0, x1, y0, y1, xx, yy;
    none = '0;
    set_reg(REG_MAP_WIDTH, w);
    set_reg(REG_MAP_HEIGHT, h);
    set_reg(REG_INFLATE_RADIUS, SIZE_W'(r));
    rad = int'(r);
    ew = used_span(w, MAX_WIDTH);
    eh = used_span(h, MAX_HEIGHT);
    fw = (ew == 0) ? 1 : ((ew < 10) ? ew : 10);
    fh = (eh == 0) ? 1 : ((eh < 10) ? eh : 10);
    fx = (ew == 0) ? 0 : $urandom_range(0, ew - fw);
    fy = (eh == 0) ? 0 : $urandom_range(0, eh - fh);
    done = 0;
    while (done < words) begin
      if ($urandom_range(0, 99) < 30) begin
        // A write near the focus area, or anywhere in the store.
        if ($urandom_range(0, 9) < 7) begin
          x = $urandom_range((fx > rad) ? fx - rad : 0,
                             (fx + fw - 1 + rad > 255) ? 255 : fx + fw - 1 + rad);
          y = $urandom_range((fy > rad) ? fy - rad : 0,
                             (fy + fh - 1 + rad > 255) ? 255 : fy + fh - 1 + rad);
        end else begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end
        send_word(KIND_WRITE, x, y, pick_value(10), 1'b0, none);
        done++;
      end else begin
        if (ew == 0 || eh == 0 || $urandom_range(0, 4) == 0) begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end else begin
          x = fx + $urandom_range(0, fw - 1);
          y = fy + $urandom_range(0, fh - 1);
        end
        if (x < ew && y < eh) begin
          clip_window(x, y, x0, x1, y0, y1);
          for (yy = y0; yy <= y1; yy++) begin
            for (xx = x0; xx <= x1; xx++) begin
              if (!cell_written[slot(xx, yy)]) begin
                send_word(KIND_WRITE, xx, yy, pick_value(3), 1'b0, none);
                done++;
              end
            end
          end
        end
        send_word(KIND_QUERY, x, y, cell_t'($urandom_range(0, 255)), 1'b0, none);
        done++;
      end
    end
  endtask

  // Result side: stall for a random count of cycles, then take one word.
  initial begin
    int n;
    wait (rst_n);
    forever begin
      n = draw_pause(rx_quiet);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Compare each accepted result word with the oldest awaited one.
  always @(posedge clk) begin : check_result
    cell_result_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_cells.size() == 0) begin
        $display("%0t: result word with none awaited: expected nothing, got value %0d oor %0b",
                 $time, out_inflated_value, out_out_of_range);
        error_count++;
      end else begin
        head = awaited_cells[0];
        awaited_cells.delete(0);
        if (out_inflated_value !== head.value) begin
          $display("%0t: inflated_value expected %0d, got %0d",
                   $time, head.value, out_inflated_value);
          error_count++;
        end
        if (out_out_of_range !== head.oor) begin
          $display("%0t: out_of_range expected %0b, got %0b",
                   $time, head.oor, out_out_of_range);
          error_count++;
        end
      end
    end
  end

  initial begin
    // Reset radius and height reach the bottom of a one-column map.
    add_row(reg_row(REG_MAP_WIDTH, 9'd1));
    add_row(write_row(0, 252, CELL_FREE));
    add_row(write_row(0, 253, CELL_FREE));
    add_row(write_row(0, 254, CELL_OCCUPIED));
    add_row(write_row(0, 255, CELL_UNKNOWN));
    add_row(query_row(0, 255, 1'b1, CELL_OCCUPIED, 1'b0));
    add_row(reg_row(REG_INFLATE_RADIUS, 9'd0));
    add_row(query_row(0, 255, 1'b1, CELL_UNKNOWN, 1'b0));
    // Single-cell map: own values, odd values and queries outside the map.
    add_row(reg_row(REG_MAP_HEIGHT, 9'd1));
    add_row(write_row(0, 0, CELL_OCCUPIED));
    add_row(query_row(0, 0, 1'b1, CELL_OCCUPIED, 1'b0));
    add_row(query_row(1, 0, 1'b1, CELL_EMPTY, 1'b1));
    add_row(query_row(255, 255, 1'b1, CELL_EMPTY, 1'b1));
    add_row(write_row(0, 0, 8'sd127));
    add_row(query_row(0, 0, 1'b1, CELL_EMPTY, 1'b0));
    add_row(write_row(0, 0, CELL_EMPTY));
    add_row(query_row(0, 0, 1'b1, CELL_EMPTY, 1'b0));
    add_row(write_row(0, 0, CELL_FREE));
    add_row(query_row(0, 0, 1'b1, CELL_FREE, 1'b0));
    // Largest radius spreads a neighbor's obstacle.
    add_row(reg_row(REG_MAP_WIDTH, 9'd2));
    add_row(reg_row(REG_INFLATE_RADIUS, 9'd15));
    add_row(write_row(1, 0, CELL_OCCUPIED));
    add_row(query_row(0, 0, 1'b1, CELL_OCCUPIED, 1'b0));
    add_row(query_row(1, 0, 1'b0, CELL_FREE, 1'b0));
    // Empty map, and a write to the spare index that must change nothing.
    add_row(reg_row(REG_MAP_WIDTH, 9'd0));
    add_row(query_row(0, 0, 1'b1, CELL_EMPTY, 1'b1));
    add_row(reg_row(REG_SPARE, 9'd511));
    add_row(query_row(0, 0, 1'b1, CELL_EMPTY, 1'b1));
    // Oversized sizes saturate at the store size.
    add_row(reg_row(REG_MAP_WIDTH, 9'd511));
    add_row(reg_row(REG_INFLATE_RADIUS, 9'd0));
    add_row(write_row(255, 0, CELL_UNKNOWN));
    add_row(query_row(255, 0, 1'b1, CELL_UNKNOWN, 1'b0));
    add_row(reg_row(REG_MAP_HEIGHT, 9'd511));
    add_row(write_row(255, 255, CELL_OCCUPIED));
    add_row(query_row(255, 255, 1'b1, CELL_OCCUPIED, 1'b0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].act == ROW_REG) begin
        set_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_word(directed_rows[i].kind, int'(directed_rows[i].x), int'(directed_rows[i].y),
                  directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    run_phase(9'd8, 9'd8, 4'd1, PHASE_WORDS);
    run_phase(9'd16, 9'd4, 4'd0, PHASE_WORDS);
    run_phase(9'd3, 9'd20, 4'd15, PHASE_WORDS);
    run_phase(9'd256, 9'd256, 4'd2, PHASE_WORDS);
    run_phase(9'd1, 9'd40, 4'd4, PHASE_WORDS);
    run_phase(9'd0, 9'd5, 4'd1, PHASE_WORDS);
    run_phase(9'd511, 9'd2, 4'd15, PHASE_WORDS);
    run_phase(9'd5, 9'd5, 4'd15, PHASE_WORDS);
    run_phase(9'd12, 9'd9, 4'd3, PHASE_WORDS);
    run_phase(9'd256, 9'd256, 4'd0, PHASE_WORDS);
    run_phase(9'd7, 9'd511, 4'd2, PHASE_WORDS);
    run_phase(9'd6, 9'd0, 4'd2, PHASE_WORDS);

    // Drain, then watch a while longer for stray result words.
    in_valid <= 1'b0;
    while (awaited_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
